// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the light bar pair matcher.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define LBPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that expr never holds outside reset.
`define LBPM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LBPM_ASSERT(lbl, prop, msg)
`define LBPM_NEVER(lbl, expr, msg)
`endif
`endif

// ----- src/lbpm_pkg.sv -----
// Types and constants of the light bar pair matcher.
// No dependencies; used by lbpm_ctrl, lbpm_datapath and light_bar_pair_matcher.
`timescale 1ns / 1ps

package lbpm_pkg;

    localparam int IDX_W = 3;   // store index field width
    localparam int CNT_W = 4;   // bar count, holds up to fifteen

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_MAX_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_MAX_TILT    = 3'd2;
    localparam logic [2:0] CFG_MIN_LENGTH  = 3'd3;
    localparam logic [2:0] CFG_MIN_SPACING = 3'd4;
    localparam logic [2:0] CFG_MAX_SPACING = 3'd5;
    localparam logic [2:0] CFG_MAX_SLOPE   = 3'd6;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_MIN_WIDTH   = 8'd8;
    localparam logic [7:0]  RST_MAX_WIDTH   = 8'd166;
    localparam logic [10:0] RST_MAX_TILT    = 11'd1040;
    localparam logic [7:0]  RST_MIN_LENGTH  = 8'd128;
    localparam logic [7:0]  RST_MIN_SPACING = 8'd8;
    localparam logic [7:0]  RST_MAX_SPACING = 8'd80;
    localparam logic [9:0]  RST_MAX_SLOPE   = 10'd64;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] bar_width;
        logic [15:0] bar_length;
        logic [10:0] tilt;
        logic        frame_end;
    } bar_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
        logic             pair_found;
        logic             overflowed;
        logic             run_end;
    } pair_result_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] len;
    } bar_entry_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;     // load the input register
        logic             bar_commit;  // test the held bar and store it
        logic [IDX_W-1:0] rd_first;
        logic [IDX_W-1:0] rd_second;
        logic             out_load;
        logic [IDX_W-1:0] out_first;
        logic [IDX_W-1:0] out_second;
        logic             out_found;
        logic             out_end;
        logic             clear;       // empty the store and drop the overflow flag
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             frame_end;
        logic [CNT_W-1:0] bar_count;
        logic             pass;
        logic             out_busy;
    } dp_status_t;

endpackage

// ----- src/lbpm_datapath.sv -----
// Datapath of the light bar pair matcher: config registers, bar test, bar store,
// pipelined pair test and result register. Depends on lbpm_pkg.
`timescale 1ns / 1ps

module lbpm_datapath #(
    parameter int MAX_BARS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [2:0]               cfg_index,
    input  logic [10:0]              cfg_data,
    input  lbpm_pkg::bar_item_t      in_item,
    input  lbpm_pkg::ctrl_cmd_t      cmd,
    input  logic                     out_stall,
    output lbpm_pkg::dp_status_t     stat,
    output logic                     out_valid,
    output lbpm_pkg::pair_result_t   out_item
);

    localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

    // configuration registers
    logic [7:0]  min_width_reg;
    logic [7:0]  max_width_reg;
    logic [10:0] max_tilt_reg;
    logic [7:0]  min_length_reg;
    logic [7:0]  min_spacing_reg;
    logic [7:0]  max_spacing_reg;
    logic [9:0]  max_slope_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_width_reg   <= lbpm_pkg::RST_MIN_WIDTH;
            max_width_reg   <= lbpm_pkg::RST_MAX_WIDTH;
            max_tilt_reg    <= lbpm_pkg::RST_MAX_TILT;
            min_length_reg  <= lbpm_pkg::RST_MIN_LENGTH;
            min_spacing_reg <= lbpm_pkg::RST_MIN_SPACING;
            max_spacing_reg <= lbpm_pkg::RST_MAX_SPACING;
            max_slope_reg   <= lbpm_pkg::RST_MAX_SLOPE;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                lbpm_pkg::CFG_MIN_WIDTH:   min_width_reg   <= cfg_data[7:0];
                lbpm_pkg::CFG_MAX_WIDTH:   max_width_reg   <= cfg_data[7:0];
                lbpm_pkg::CFG_MAX_TILT:    max_tilt_reg    <= cfg_data;
                lbpm_pkg::CFG_MIN_LENGTH:  min_length_reg  <= cfg_data[7:0];
                lbpm_pkg::CFG_MIN_SPACING: min_spacing_reg <= cfg_data[7:0];
                lbpm_pkg::CFG_MAX_SPACING: max_spacing_reg <= cfg_data[7:0];
                lbpm_pkg::CFG_MAX_SLOPE:   max_slope_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input register
    lbpm_pkg::bar_item_t in_reg;

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            in_reg <= in_item;
        end
    end

    // bar test
    logic [23:0] width_scaled;
    logic [23:0] lo_width;
    logic [23:0] hi_width;
    logic        bar_keep;
    logic        store_full;

    assign width_scaled = {in_reg.bar_width, 8'd0};
    assign lo_width     = 24'(min_width_reg) * 24'(in_reg.bar_length);
    assign hi_width     = 24'(max_width_reg) * 24'(in_reg.bar_length);
    assign bar_keep     = (lo_width < width_scaled) && (width_scaled < hi_width)
                          && (in_reg.tilt < max_tilt_reg);

    // count and overflow
    logic [lbpm_pkg::CNT_W-1:0] bar_count_reg;
    logic                       overflow_reg;

    assign store_full = (bar_count_reg >= lbpm_pkg::CNT_W'(MAX_BARS));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bar_count_reg <= '0;
            overflow_reg  <= 1'b0;
        end
        else if (cmd.clear) begin
            bar_count_reg <= '0;
            overflow_reg  <= 1'b0;
        end
        else if (cmd.bar_commit && bar_keep) begin
            if (store_full) begin
                overflow_reg <= 1'b1;
            end
            else begin
                bar_count_reg <= bar_count_reg + 1'b1;
            end
        end
    end

    // bar store, one write port and two registered read ports
    lbpm_pkg::bar_entry_t store_mem [MAX_BARS];
    lbpm_pkg::bar_entry_t rd_a_reg;
    lbpm_pkg::bar_entry_t rd_b_reg;

    always_ff @(posedge clk) begin
        if (cmd.bar_commit && bar_keep && !store_full) begin
            store_mem[bar_count_reg[AW-1:0]] <= '{cx:  in_reg.center_x,
                                                  cy:  in_reg.center_y,
                                                  len: in_reg.bar_length};
        end
        rd_a_reg <= store_mem[cmd.rd_first[AW-1:0]];
        rd_b_reg <= store_mem[cmd.rd_second[AW-1:0]];
    end

    // stage A: differences, length sum, shorter and longer
    logic [15:0] dx_a_reg;
    logic [15:0] dy_a_reg;
    logic [16:0] sum_a_reg;
    logic [15:0] shorter_a_reg;
    logic [15:0] longer_a_reg;

    always_ff @(posedge clk) begin
        dx_a_reg  <= (rd_a_reg.cx > rd_b_reg.cx) ? rd_a_reg.cx - rd_b_reg.cx
                                                 : rd_b_reg.cx - rd_a_reg.cx;
        dy_a_reg  <= (rd_a_reg.cy > rd_b_reg.cy) ? rd_a_reg.cy - rd_b_reg.cy
                                                 : rd_b_reg.cy - rd_a_reg.cy;
        sum_a_reg <= 17'(rd_a_reg.len) + 17'(rd_b_reg.len);
        if (rd_a_reg.len < rd_b_reg.len) begin
            shorter_a_reg <= rd_a_reg.len;
            longer_a_reg  <= rd_b_reg.len;
        end
        else begin
            shorter_a_reg <= rd_b_reg.len;
            longer_a_reg  <= rd_a_reg.len;
        end
    end

    // stage B: first products
    logic [31:0] dx2_b_reg;
    logic [31:0] dy2_b_reg;
    logic [24:0] lo_b_reg;
    logic [24:0] hi_b_reg;
    logic [23:0] len_lim_b_reg;
    logic [25:0] slope_lim_b_reg;
    logic [15:0] shorter_b_reg;
    logic [15:0] dy_b_reg;
    logic        dx_nz_b_reg;

    always_ff @(posedge clk) begin
        dx2_b_reg       <= 32'(dx_a_reg) * 32'(dx_a_reg);
        dy2_b_reg       <= 32'(dy_a_reg) * 32'(dy_a_reg);
        lo_b_reg        <= 25'(min_spacing_reg) * 25'(sum_a_reg);
        hi_b_reg        <= 25'(max_spacing_reg) * 25'(sum_a_reg);
        len_lim_b_reg   <= 24'(min_length_reg) * 24'(longer_a_reg);
        slope_lim_b_reg <= 26'(max_slope_reg) * 26'(dx_a_reg);
        shorter_b_reg   <= shorter_a_reg;
        dy_b_reg        <= dy_a_reg;
        dx_nz_b_reg     <= (dx_a_reg != 16'd0);
    end

    // stage C: squared spacing bounds, distance sum, length and slope tests
    logic [32:0] d2_c_reg;
    logic [49:0] lo2_c_reg;
    logic [49:0] hi2_c_reg;
    logic        len_ok_c_reg;
    logic        slope_ok_c_reg;

    always_ff @(posedge clk) begin
        d2_c_reg       <= 33'(dx2_b_reg) + 33'(dy2_b_reg);
        lo2_c_reg      <= 50'(lo_b_reg) * 50'(lo_b_reg);
        hi2_c_reg      <= 50'(hi_b_reg) * 50'(hi_b_reg);
        len_ok_c_reg   <= ({shorter_b_reg, 8'd0} > len_lim_b_reg);
        slope_ok_c_reg <= dx_nz_b_reg && (26'({dy_b_reg, 8'd0}) < slope_lim_b_reg);
    end

    // stage D: spacing window and final verdict
    logic [49:0] d2_scaled;
    logic        pass_reg;

    assign d2_scaled = {7'd0, d2_c_reg, 10'd0};

    always_ff @(posedge clk) begin
        pass_reg <= (lo2_c_reg < d2_scaled) && (d2_scaled < hi2_c_reg)
                    && len_ok_c_reg && slope_ok_c_reg;
    end

    // result register
    logic                   out_valid_reg;
    lbpm_pkg::pair_result_t out_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            out_reg <= '{first_index:  cmd.out_first,
                         second_index: cmd.out_second,
                         pair_found:   cmd.out_found,
                         overflowed:   overflow_reg,
                         run_end:      cmd.out_end};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign stat = '{frame_end: in_reg.frame_end,
                    bar_count: bar_count_reg,
                    pass:      pass_reg,
                    out_busy:  out_valid_reg && out_stall};

endmodule

// ----- src/lbpm_ctrl.sv -----
// Controller of the light bar pair matcher: sequences the bar test and the pair walk.
// Depends on lbpm_pkg; drives lbpm_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module lbpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lbpm_pkg::dp_status_t  stat,
    output lbpm_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BAR,
        S_START,
        S_READ,
        S_STG_A,
        S_STG_B,
        S_STG_C,
        S_STG_D,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t                     state_reg,  state_next;
    logic [lbpm_pkg::IDX_W-1:0] i_reg,      i_next;
    logic [lbpm_pkg::IDX_W-1:0] j_reg,      j_next;
    logic [lbpm_pkg::IDX_W-1:0] hold_i_reg, hold_i_next;
    logic [lbpm_pkg::IDX_W-1:0] hold_j_reg, hold_j_next;
    logic                       hold_reg,   hold_next;

    logic [lbpm_pkg::CNT_W-1:0] j_plus1;
    logic [lbpm_pkg::CNT_W-1:0] i_plus2;

    assign j_plus1 = lbpm_pkg::CNT_W'(j_reg) + 1'b1;
    assign i_plus2 = lbpm_pkg::CNT_W'(i_reg) + 2'd2;

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        hold_i_next = hold_i_reg;
        hold_j_next = hold_j_reg;
        hold_next   = hold_reg;
        cmd         = '0;
        cmd.rd_first  = i_reg;
        cmd.rd_second = j_reg;
        cmd.out_first  = hold_i_reg;
        cmd.out_second = hold_j_reg;
        cmd.out_found  = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = in_valid;
                if (in_valid) begin
                    state_next = S_BAR;
                end
            end
            S_BAR: begin
                cmd.bar_commit = 1'b1;
                state_next = stat.frame_end ? S_START : S_IDLE;
            end
            S_START: begin
                i_next    = '0;
                j_next    = lbpm_pkg::IDX_W'(1);
                hold_next = 1'b0;
                state_next = (stat.bar_count < lbpm_pkg::CNT_W'(2)) ? S_FINISH : S_READ;
            end
            S_READ:  state_next = S_STG_A;
            S_STG_A: state_next = S_STG_B;
            S_STG_B: state_next = S_STG_C;
            S_STG_C: state_next = S_STG_D;
            S_STG_D: state_next = S_DECIDE;
            S_DECIDE: begin
                // a passing pair pushes out the one held before it
                if (!(stat.pass && hold_reg && stat.out_busy)) begin
                    if (stat.pass) begin
                        cmd.out_load = hold_reg;
                        hold_i_next  = i_reg;
                        hold_j_next  = j_reg;
                        hold_next    = 1'b1;
                    end
                    if (j_plus1 < stat.bar_count) begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_READ;
                    end
                    else if ((i_plus2 + 1'b1) < stat.bar_count + 1'b1 &&
                             i_plus2 < stat.bar_count) begin
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 2'd2;
                        state_next = S_READ;
                    end
                    else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                // last held pair closes the frame, or an empty result if none
                cmd.out_end = 1'b1;
                if (!hold_reg) begin
                    cmd.out_first  = '0;
                    cmd.out_second = '0;
                    cmd.out_found  = 1'b0;
                end
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    hold_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            hold_i_reg <= '0;
            hold_j_reg <= '0;
            hold_reg   <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            hold_i_reg <= hold_i_next;
            hold_j_reg <= hold_j_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

// ----- src/light_bar_pair_matcher.sv -----
// Top level of the light bar pair matcher: ports, controller and datapath.
// Depends on lbpm_pkg, lbpm_ctrl, lbpm_datapath and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid / in_stall   | in_item  (bar_item_t)
//   out     | output    | out_valid / out_stall | out_item (pair_result_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index (3 b), cfg_data (11 b)
//
// A bar item is captured, then given the width/length/tilt test and the store write.
// An item marked frame_end then walks every stored pair through a store read and a
// four-stage multiply-compare pipeline before each decision, and a last step closes
// the frame. A waiting result stalls the pair walk only when a newer pair is due.
// Reset clears the config registers to their defaults, the bar count and the flags;
// the bar store itself needs no clearing. cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module light_bar_pair_matcher #(
    parameter int MAX_BARS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lbpm_pkg::bar_item_t    in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lbpm_pkg::pair_result_t out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [10:0]            cfg_data
);

    lbpm_pkg::ctrl_cmd_t  cmd;
    lbpm_pkg::dp_status_t stat;

    // config writes land at once; the user must write only while the block is idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    lbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lbpm_datapath #(
        .MAX_BARS (MAX_BARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // shape checks on the result on offer
    logic empty_bad;   // empty result that is not final or carries indexes
    logic order_bad;   // reported pair whose outer index is not below the inner one

    assign empty_bad = out_valid && !out_item.pair_found
                       && (!out_item.run_end || (out_item.first_index != '0)
                           || (out_item.second_index != '0));
    assign order_bad = out_valid && out_item.pair_found
                       && (out_item.first_index >= out_item.second_index);

    // an empty result always closes its frame and carries zero indexes
    `LBPM_NEVER(a_empty_closes, empty_bad, "empty result not final")
    // reported pairs keep the outer index below the inner one
    `LBPM_NEVER(a_pair_order, order_bad, "pair indexes out of order")
    // the store never counts past its depth
    `LBPM_NEVER(a_count_bound, stat.bar_count > lbpm_pkg::CNT_W'(MAX_BARS), "count too high")
    // a result is never overwritten while the sink holds it off
    `LBPM_NEVER(a_no_overwrite, cmd.out_load && out_valid && out_stall, "result overwritten")

endmodule

// ----- tb/tb_light_bar_pair_matcher.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for light_bar_pair_matcher: directed and random bar items,
// an untimed predictor of bar screening and pair matching, and an in-order result check.
// Depends on lbpm_pkg and the RTL of light_bar_pair_matcher.

module tb_light_bar_pair_matcher;

    localparam int NBARS      = 8;     // store depth given to the block
    localparam int WATCH_MAX  = 3000;  // cycles without any handshake before giving up
    localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int SETTLE     = 200;   // quiet cycles after the last result of a phase

    // index with no register behind it; writes to it must change nothing
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    lbpm_pkg::bar_item_t    in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    lbpm_pkg::pair_result_t out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [10:0]            cfg_data  = '0;

    light_bar_pair_matcher #(
        .MAX_BARS (NBARS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    lbpm_pkg::bar_item_t    bar_queue[$];       // items waiting to be offered to the block
    lbpm_pkg::pair_result_t expected_pairs[$];  // predicted results, oldest first

    // predictor copy of thresholds and bar store
    logic [10:0]  thr [0:6];
    logic [15:0]  st_x [NBARS];
    logic [15:0]  st_y [NBARS];
    logic [15:0]  st_len [NBARS];
    int           st_count;
    bit           st_over;

    int  send_gap_pct;   // chance that the sender idles on a free cycle
    int  stall_pct;      // chance that the receiver stalls on a cycle
    int  hold_asks;      // hold-off requests from the sequencer
    int  hold_served;    // hold-off requests taken by the stall process
    int  hold_left;
    bit  in_taken;       // input item accepted at the last rising edge
    int  quiet;

    int  mismatches;
    int  bars_sent;
    int  frames_closed;
    int  pairs_expected;
    int  overflow_frames;
    int  results_seen;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [10:0] cfg_mask(input logic [2:0] idx);
        case (idx)
            lbpm_pkg::CFG_MAX_TILT:  return 11'h7FF;
            lbpm_pkg::CFG_MAX_SLOPE: return 11'h3FF;
            default:                 return 11'h0FF;
        endcase
    endfunction

    // Keep a bar when width/length is strictly inside the window and tilt is below limit.
    function automatic bit bar_kept(input lbpm_pkg::bar_item_t b);
        longint unsigned w;
        longint unsigned l;
        bit lo_ok;
        bit hi_ok;
        w     = 64'(b.bar_width);
        l     = 64'(b.bar_length);
        lo_ok = longint'(thr[lbpm_pkg::CFG_MIN_WIDTH]) * l < 256 * w;
        hi_ok = 256 * w < longint'(thr[lbpm_pkg::CFG_MAX_WIDTH]) * l;
        return lo_ok && hi_ok && (b.tilt < thr[lbpm_pkg::CFG_MAX_TILT]);
    endfunction

    // Length similarity, squared spacing window and slope, all as exact products.
    function automatic bit pair_passes(input int a, input int b);
        longint unsigned la, lb, xa, xb, ya, yb;
        longint unsigned shorter, longer, dx, dy, sum, d2, lo, hi;
        bit len_ok, spc_ok, slope_ok;
        la      = 64'(st_len[a]);
        lb      = 64'(st_len[b]);
        xa      = 64'(st_x[a]);
        xb      = 64'(st_x[b]);
        ya      = 64'(st_y[a]);
        yb      = 64'(st_y[b]);
        shorter = (la < lb) ? la : lb;
        longer  = (la < lb) ? lb : la;
        dx      = (xa > xb) ? xa - xb : xb - xa;
        dy      = (ya > yb) ? ya - yb : yb - ya;
        sum     = la + lb;
        d2      = 1024 * (dx * dx + dy * dy);
        lo      = longint'(thr[lbpm_pkg::CFG_MIN_SPACING]) * sum;
        hi      = longint'(thr[lbpm_pkg::CFG_MAX_SPACING]) * sum;
        len_ok  = 256 * shorter > longint'(thr[lbpm_pkg::CFG_MIN_LENGTH]) * longer;
        spc_ok  = (lo * lo < d2) && (d2 < hi * hi);
        // a vertical pair never passes, coincident centers included
        slope_ok = (dx != 0) && (256 * dy < longint'(thr[lbpm_pkg::CFG_MAX_SLOPE]) * dx);
        return len_ok && spc_ok && slope_ok;
    endfunction

    // Screen one accepted bar, store or drop it, and on frame end queue the frame's results.
    task automatic match_bar(input lbpm_pkg::bar_item_t b);
        lbpm_pkg::pair_result_t frame_pairs[$];
        lbpm_pkg::pair_result_t r;
        int i;
        int j;
        if (bar_kept(b))
        begin
            if (st_count < NBARS)
            begin
                st_x[st_count]   = b.center_x;
                st_y[st_count]   = b.center_y;
                st_len[st_count] = b.bar_length;
                st_count++;
            end
            else
                st_over = 1'b1;
        end
        if (b.frame_end)
        begin
            for (i = 0; i < st_count; i++)
                for (j = i + 1; j < st_count; j++)
                    if (pair_passes(i, j))
                    begin
                        r              = '0;
                        r.first_index  = i[lbpm_pkg::IDX_W-1:0];
                        r.second_index = j[lbpm_pkg::IDX_W-1:0];
                        r.pair_found   = 1'b1;
                        r.overflowed   = st_over;
                        frame_pairs    = {frame_pairs, r};
                    end
            pairs_expected += frame_pairs.size();
            // no pair: one empty result still closes the frame
            if (frame_pairs.size() == 0)
            begin
                r            = '0;
                r.overflowed = st_over;
                frame_pairs  = {frame_pairs, r};
            end
            frame_pairs[frame_pairs.size() - 1].run_end = 1'b1;
            expected_pairs = {expected_pairs, frame_pairs};
            frames_closed++;
            if (st_over)
                overflow_frames++;
            st_count = 0;
            st_over  = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic check_result(input lbpm_pkg::pair_result_t got);
        lbpm_pkg::pair_result_t want;
        results_seen++;
        if (expected_pairs.size() == 0)
        begin
            report_mismatch("result with nothing pending", 32'(got), '0);
            return;
        end
        want = expected_pairs.pop_front();
        if (got.first_index !== want.first_index)
            report_mismatch("first_index", 32'(got.first_index), 32'(want.first_index));
        if (got.second_index !== want.second_index)
            report_mismatch("second_index", 32'(got.second_index), 32'(want.second_index));
        if (got.pair_found !== want.pair_found)
            report_mismatch("pair_found", 32'(got.pair_found), 32'(want.pair_found));
        if (got.overflowed !== want.overflowed)
            report_mismatch("overflowed", 32'(got.overflowed), 32'(want.overflowed));
        if (got.run_end !== want.run_end)
            report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, predict, check, watch for hangs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken = 1'b0;
        else
        begin
            in_taken = in_valid && !in_stall;
            // check results first: a result never stems from the item taken at this edge
            if (out_valid && !out_stall)
                check_result(out_item);
            if (in_taken)
            begin
                match_bar(in_item);
                bars_sent++;
            end
            if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCH_MAX)
            begin
                $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                         $realtime, quiet, expected_pairs.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer the next bar at the falling edge once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            // hold valid low on a random gap; never drop an item still on offer
            if (bar_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                in_item  <= bar_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a counted long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_LEN;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_bar(input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] w, input logic [15:0] l,
                                     input logic [10:0] t, input logic e);
        lbpm_pkg::bar_item_t b;
        b.center_x   = x;
        b.center_y   = y;
        b.bar_width  = w;
        b.bar_length = l;
        b.tilt       = t;
        b.frame_end  = e;
        bar_queue    = {bar_queue, b};
    endfunction

    // One well-formed frame: bars of similar size laid out in a rough row, so that
    // most of them survive screening and many neighbors form pairs.
    task automatic gen_frame(inout int made);
        int k, i, base_len, len, w, x, y, tilt;
        k = ($urandom_range(0, 9) < 2) ? $urandom_range(9, 11) : $urandom_range(1, 6);
        base_len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 160)
                                               : $urandom_range(160, 2000);
        x = $urandom_range(0, 20000);
        y = $urandom_range(0, 60000);
        for (i = 0; i < k; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, 65535);
            else
                len = base_len * $urandom_range(180, 256) / 256 + 1;
            w    = len * $urandom_range(10, 180) / 256;
            tilt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1440)
                                               : $urandom_range(0, 900);
            push_bar(x[15:0], 16'(y + $urandom_range(0, len / 4) - len / 8), w[15:0],
                     len[15:0], tilt[10:0], i == k - 1);
            x = x + base_len * $urandom_range(6, 90) / 16;
        end
        made += k;
    endtask

    // Mostly frames, with some raw noise ahead of them; every batch ends on a frame end.
    task automatic gen_random(input int count);
        int made;
        int n;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    push_bar(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             11'($urandom_range(0, 1440)), $urandom_range(0, 7) == 0);
            end
            gen_frame(made);
        end
    endtask

    // Wait until every bar is taken and every result has come, then let the block settle.
    task automatic wait_drained();
        while (bar_queue.size() != 0 || in_valid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx != CFG_UNUSED)
            thr[idx] = val & cfg_mask(idx);
    endtask

    task automatic load_thresholds(input logic [10:0] min_w, input logic [10:0] max_w,
                                   input logic [10:0] tilt, input logic [10:0] min_len,
                                   input logic [10:0] min_sp, input logic [10:0] max_sp,
                                   input logic [10:0] slope);
        cfg_write(lbpm_pkg::CFG_MIN_WIDTH, min_w);
        cfg_write(lbpm_pkg::CFG_MAX_WIDTH, max_w);
        cfg_write(lbpm_pkg::CFG_MAX_TILT, tilt);
        cfg_write(lbpm_pkg::CFG_MIN_LENGTH, min_len);
        cfg_write(lbpm_pkg::CFG_MIN_SPACING, min_sp);
        cfg_write(lbpm_pkg::CFG_MAX_SPACING, max_sp);
        cfg_write(lbpm_pkg::CFG_MAX_SLOPE, slope);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        thr[lbpm_pkg::CFG_MIN_WIDTH]   = 11'(lbpm_pkg::RST_MIN_WIDTH);
        thr[lbpm_pkg::CFG_MAX_WIDTH]   = 11'(lbpm_pkg::RST_MAX_WIDTH);
        thr[lbpm_pkg::CFG_MAX_TILT]    = lbpm_pkg::RST_MAX_TILT;
        thr[lbpm_pkg::CFG_MIN_LENGTH]  = 11'(lbpm_pkg::RST_MIN_LENGTH);
        thr[lbpm_pkg::CFG_MIN_SPACING] = 11'(lbpm_pkg::RST_MIN_SPACING);
        thr[lbpm_pkg::CFG_MAX_SPACING] = 11'(lbpm_pkg::RST_MAX_SPACING);
        thr[lbpm_pkg::CFG_MAX_SLOPE]   = 11'(lbpm_pkg::RST_MAX_SLOPE);
        st_count     = 0;
        st_over      = 1'b0;
        send_gap_pct = 27;
        stall_pct    = 79;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset thresholds, sender idles 27%, receiver 79%.
        // Zero width and zero length on lone frame ends: both rejected, empty result.
        push_bar(16'd0, 16'd0, 16'd0, 16'd1, 11'd0, 1'b1);
        push_bar(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 11'd1440, 1'b1);
        // clean pair two lengths apart; tilt at the limit is rejected, just below is kept
        push_bar(16'd1000, 16'd1000, 16'd300, 16'd800, 11'd0, 1'b0);
        push_bar(16'd5000, 16'd1000, 16'd300, 16'd800, 11'd1040, 1'b0);
        push_bar(16'd2600, 16'd1000, 16'd300, 16'd800, 11'd1039, 1'b1);
        // vertical pair fails the slope test
        push_bar(16'd4000, 16'd4000, 16'd300, 16'd800, 11'd0, 1'b0);
        push_bar(16'd4000, 16'd5600, 16'd300, 16'd800, 11'd0, 1'b1);
        // coincident centers: dx and dy both zero
        push_bar(16'd7000, 16'd7000, 16'd300, 16'd800, 11'd0, 1'b0);
        push_bar(16'd7000, 16'd7000, 16'd300, 16'd800, 11'd0, 1'b1);
        // ten kept bars in a row overflow the store; a rejected bar in between must not
        for (i = 0; i < 10; i++)
        begin
            if (i == 4)
                push_bar(16'd100, 16'd100, 16'd0, 16'd800, 11'd0, 1'b0);
            push_bar(16'(1000 + 1600 * i), 16'd20000, 16'd300, 16'd800, 11'd0, i == 9);
        end
        // width ratio exactly on each bound is rejected; overflow is cleared by now
        push_bar(16'd100, 16'd100, 16'd8, 16'd256, 11'd0, 1'b0);
        push_bar(16'd900, 16'd100, 16'd166, 16'd256, 11'd0, 1'b1);
        wait_drained();

        // Mixed thresholds; upper data bits on 8-bit registers must be dropped,
        // and the unused index must leave everything alone.
        cfg_write(CFG_UNUSED, 11'h7FF);
        load_thresholds(11'h714, 11'd200, 11'd1200, 11'h664, 11'd4, 11'd96, 11'd300);
        gen_random(40);
        // pause the sender until every pending result is back
        wait_drained();
        gen_random(40);
        wait_drained();

        // Swap idling: sender 79%, receiver 27%. First the strictest extremes,
        // where every bar is rejected, then the reset values written back.
        send_gap_pct = 79;
        stall_pct    = 27;
        load_thresholds(11'd255, 11'd0, 11'd0, 11'd255, 11'd255, 11'd0, 11'd0);
        gen_random(30);
        wait_drained();
        load_thresholds(11'(lbpm_pkg::RST_MIN_WIDTH), 11'(lbpm_pkg::RST_MAX_WIDTH),
                        lbpm_pkg::RST_MAX_TILT, 11'(lbpm_pkg::RST_MIN_LENGTH),
                        11'(lbpm_pkg::RST_MIN_SPACING), 11'(lbpm_pkg::RST_MAX_SPACING),
                        11'(lbpm_pkg::RST_MAX_SLOPE));
        gen_random(70);
        wait_drained();

        // No idling, loosest extremes so frames carry many pairs. Start with a long
        // receiver hold-off while bars keep coming, so the block backs up on its input.
        send_gap_pct = 0;
        stall_pct    = 0;
        load_thresholds(11'd0, 11'd255, 11'd1440, 11'd0, 11'd0, 11'd255, 11'd1023);
        hold_asks++;
        gen_random(90);
        wait_drained();

        $display("Covered %0d bar items over %0d frames: %0d pairs, %0d overflowed frames.",
                 bars_sent, frames_closed, pairs_expected, overflow_frames);
        $display("Thresholds at reset, mixed, both extremes; %0d results checked.",
                 results_seen);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
